// ===== src/pta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants of the primitive triangle assembler.
// ----------------------------------------------------------------------------
package pta_pkg;

   localparam int REF_W        = 16;
   localparam int SLOT_W       = 8;
   localparam int MODE_W       = 3;
   localparam int MAX_CORNERS  = 6;
   localparam int CNT_W        = 3;
   localparam int SLOT_CODES   = 1 << SLOT_W;
   localparam int DEF_TRANSFORM_SLOTS = 256;

   localparam logic [MODE_W-1:0] MODE_TRIANGLES  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STRIP      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FAN        = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POLYGON    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUADS      = 3'd4;
   localparam logic [MODE_W-1:0] MODE_QUAD_STRIP = 3'd5;

   typedef struct packed {
      logic [REF_W-1:0]  vertex_ref;
      logic              shape_start;
      logic [MODE_W-1:0] prim_mode;
      logic              filled;
      logic [SLOT_W-1:0] transform_slot;
   } req_type;

   typedef struct packed {
      logic [REF_W-1:0]  corner_ref;
      logic [SLOT_W-1:0] corner_transform;
      logic              last_of_run;
   } rsp_type;

   // corners completed by one request
   typedef struct packed {
      logic [CNT_W-1:0]                   count;
      logic [SLOT_W-1:0]                  slot;
      logic [MAX_CORNERS-1:0][REF_W-1:0]  refs;
   } batch_type;

endpackage

// ===== src/primitive_triangle_assembler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_triangle_assembler_top
// Turns a stream of vertex references into triangle corners.
// ----------------------------------------------------------------------------
// Each accepted request is assembled in the cycle it is taken; the corners it
// completes (none, three or six) land in an output batch register and leave
// one per cycle while rsp_stall is low, last_of_run marking the final one. A spare batch register
// takes the next request while the current corners drain, so req_stall rises
// only while both are occupied and does not follow rsp_stall combinationally.
// A request with no corners sends nothing to the output; otherwise the output
// sets the pace at one corner per cycle unless rsp_stall holds it.
// With the output idle, the first corner of a request is offered in the cycle
// after it is taken. Transform slots wrap modulo TRANSFORM_SLOTS.
module primitive_triangle_assembler_top
   import pta_pkg::*;
#(
   parameter int TRANSFORM_SLOTS = DEF_TRANSFORM_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   batch_type batch;
   logic      free;
   logic      accept;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   pta_assembler #(
      .TRANSFORM_SLOTS (TRANSFORM_SLOTS)
   ) u_assembler (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .batch  (batch)
   );

   pta_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .batch     (batch),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/pta_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_assembler
// Shape tracking state and triangle corner selection for one request.
// ----------------------------------------------------------------------------
module pta_assembler
   import pta_pkg::*;
#(
   parameter int TRANSFORM_SLOTS = DEF_TRANSFORM_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   output batch_type batch
);

   logic [REF_W-1:0]  first_ff, first_in;
   logic [REF_W-1:0]  r0_ff, r1_ff, r2_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        seen_ff, seen_in;

   logic [1:0]        pos;
   logic [1:0]        seen;
   logic [2:0]        pos_inc;
   logic [REF_W-1:0]  cur;
   logic [SLOT_W-1:0] wrap_table [SLOT_CODES];

   for (genvar g = 0; g < SLOT_CODES; g++) begin : g_wrap
      assign wrap_table[g] = SLOT_W'(g % TRANSFORM_SLOTS);
   end

   assign cur      = req.vertex_ref;
   assign pos      = req.shape_start ? 2'd0 : phase_ff;
   assign seen     = req.shape_start ? 2'd0 : seen_ff;
   assign first_in = (seen == 2'd0) ? cur : first_ff;
   assign seen_in  = (seen == 2'd3) ? 2'd3 : seen + 2'd1;
   assign pos_inc  = {1'b0, pos} + 3'd1;

   always_comb begin
      case (req.prim_mode)
         MODE_TRIANGLES:             phase_in = (pos_inc >= 3'd3) ? 2'(pos_inc - 3'd3)
                                                                  : pos_inc[1:0];
         MODE_STRIP, MODE_QUAD_STRIP: phase_in = {1'b0, pos_inc[0]};
         default:                     phase_in = pos_inc[1:0];
      endcase
   end

   always_comb begin
      batch.count = '0;
      batch.slot  = wrap_table[req.transform_slot];
      batch.refs  = '0;
      if (req.filled) begin
         case (req.prim_mode)
            MODE_TRIANGLES: begin
               if (pos == 2'd2 && seen >= 2'd2) begin
                  batch.count   = 3'd3;
                  batch.refs[0] = r1_ff;
                  batch.refs[1] = r0_ff;
                  batch.refs[2] = cur;
               end
            end
            MODE_STRIP: begin
               if (seen >= 2'd2) begin
                  batch.count   = 3'd3;
                  batch.refs[0] = pos[0] ? r0_ff : r1_ff;
                  batch.refs[1] = pos[0] ? r1_ff : r0_ff;
                  batch.refs[2] = cur;
               end
            end
            MODE_FAN, MODE_POLYGON: begin
               if (seen >= 2'd2) begin
                  batch.count   = 3'd3;
                  batch.refs[0] = first_in;
                  batch.refs[1] = r0_ff;
                  batch.refs[2] = cur;
               end
            end
            MODE_QUADS: begin
               if (pos == 2'd3 && seen == 2'd3) begin
                  batch.count   = 3'd6;
                  batch.refs[0] = r2_ff;
                  batch.refs[1] = r1_ff;
                  batch.refs[2] = r0_ff;
                  batch.refs[3] = r2_ff;
                  batch.refs[4] = r0_ff;
                  batch.refs[5] = cur;
               end
            end
            MODE_QUAD_STRIP: begin
               if (pos[0] && seen == 2'd3) begin
                  batch.count   = 3'd6;
                  batch.refs[0] = r2_ff;
                  batch.refs[1] = r1_ff;
                  batch.refs[2] = cur;
                  batch.refs[3] = r2_ff;
                  batch.refs[4] = cur;
                  batch.refs[5] = r0_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         r0_ff    <= '0;
         r1_ff    <= '0;
         r2_ff    <= '0;
         phase_ff <= '0;
         seen_ff  <= '0;
      end else if (accept) begin
         first_ff <= first_in;
         r0_ff    <= cur;
         r1_ff    <= r0_ff;
         r2_ff    <= r1_ff;
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== src/pta_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_emitter
// Hands out the corners of one request one per cycle when not stalled, with a
// spare batch register for the next request while the current corners drain.
// ----------------------------------------------------------------------------
module pta_emitter
   import pta_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  batch_type batch,
   output logic      free,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   batch_type        batch_ff, batch_in;
   batch_type        hold_ff, hold_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             take;
   logic             last;
   logic             done;

   assign rsp_valid = (batch_ff.count != '0);
   assign take      = rsp_valid && !rsp_stall;
   assign last      = (idx_ff == batch_ff.count - CNT_W'(1));
   assign done      = !rsp_valid || (take && last);
   assign free      = (hold_ff.count == '0);

   assign rsp_data.corner_ref       = batch_ff.refs[idx_ff];
   assign rsp_data.corner_transform = batch_ff.slot;
   assign rsp_data.last_of_run      = last;

   // load is only raised while the spare register is empty
   always_comb begin
      batch_in = batch_ff;
      hold_in  = hold_ff;
      idx_in   = idx_ff;
      if (take) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (done) begin
         idx_in = '0;
         if (!free) begin
            batch_in      = hold_ff;
            hold_in.count = '0;
         end else if (load) begin
            batch_in = batch;
         end else begin
            batch_in.count = '0;
         end
      end else if (load) begin
         hold_in = batch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= '0;
         hold_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         batch_ff <= batch_in;
         hold_ff  <= hold_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== src/pta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_checker
// Port-level checks of the primitive triangle assembler.
// ----------------------------------------------------------------------------
module pta_checker
   import pta_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run |=> rsp_valid)
      else $error("run ended without last_of_run");

endmodule

bind primitive_triangle_assembler_top pta_checker u_pta_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the primitive triangle assembler.
// ----------------------------------------------------------------------------
// A queue of vertex requests goes through a valid/stall driver. Directed
// shapes come first, one for each primitive mode, with unfilled and unknown
// modes among them. Random shapes follow, with some noise mixed in. An
// assembler model predicts the corners of every accepted request. The monitor
// checks each corner field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import pta_pkg::*;

   localparam int SLOT_WRAP   = DEF_TRANSFORM_SLOTS;
   localparam int ITEM_TARGET = 170;
   localparam int CALM_TAIL   = 30;
   localparam int DRAIN_AT    = 14;
   localparam int LIMIT       = 200000;
   localparam logic [MODE_W-1:0] MODE_NONE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_NONE_B = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_corners[$];

   // assembler model state
   logic [REF_W-1:0] asm_first = '0;
   logic [REF_W-1:0] asm_hist[3] = '{default: '0};
   logic [1:0]       asm_phase = '0;
   logic [1:0]       asm_seen = '0;

   int errors = 0;
   int requests_taken = 0;
   int corners_checked = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int sent = 0;
   bit drain_wait = 1'b0;

   primitive_triangle_assembler_top #(
      .TRANSFORM_SLOTS(SLOT_WRAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic push_vertex(input logic [REF_W-1:0] vref, input logic start,
                              input logic [MODE_W-1:0] mode, input logic fill,
                              input logic [SLOT_W-1:0] slot);
      req_type r;
      r.vertex_ref     = vref;
      r.shape_start    = start;
      r.prim_mode      = mode;
      r.filled         = fill;
      r.transform_slot = slot;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic push_shape(input logic [MODE_W-1:0] mode, input logic fill,
                             input logic [SLOT_W-1:0] slot, input int len);
      for (int i = 0; i < len; i++)
         push_vertex(REF_W'($urandom), i == 0, mode, fill, slot);
   endtask

   task automatic assemble_corners(input req_type r);
      logic [REF_W-1:0]  c[MAX_CORNERS];
      logic [REF_W-1:0]  cur, h0, h1, h2;
      logic [SLOT_W-1:0] slot;
      int                pos, seen, modulus, n;
      rsp_type           corner;
      cur  = r.vertex_ref;
      h0   = asm_hist[0];
      h1   = asm_hist[1];
      h2   = asm_hist[2];
      slot = SLOT_W'(int'(r.transform_slot) % SLOT_WRAP);
      pos  = r.shape_start ? 0 : int'(asm_phase);
      seen = r.shape_start ? 0 : int'(asm_seen);
      n    = 0;
      if (seen == 0)
         asm_first = cur;
      if (r.filled) begin
         case (r.prim_mode)
            MODE_TRIANGLES: if (pos == 2 && seen >= 2) begin
               c[0] = h1; c[1] = h0; c[2] = cur; n = 3;
            end
            MODE_STRIP: if (seen >= 2) begin
               c[0] = (pos % 2 == 0) ? h1 : h0;
               c[1] = (pos % 2 == 0) ? h0 : h1;
               c[2] = cur;
               n = 3;
            end
            MODE_FAN, MODE_POLYGON: if (seen >= 2) begin
               c[0] = asm_first; c[1] = h0; c[2] = cur; n = 3;
            end
            MODE_QUADS: if (pos == 3 && seen >= 3) begin
               c[0] = h2; c[1] = h1; c[2] = h0;
               c[3] = h2; c[4] = h0; c[5] = cur;
               n = 6;
            end
            MODE_QUAD_STRIP: if (pos % 2 == 1 && seen >= 3) begin
               c[0] = h2; c[1] = h1; c[2] = cur;
               c[3] = h2; c[4] = cur; c[5] = h0;
               n = 6;
            end
            default: ;
         endcase
      end
      for (int i = 0; i < n; i++) begin
         corner.corner_ref       = c[i];
         corner.corner_transform = slot;
         corner.last_of_run      = (i == n - 1);
         expected_corners.insert(expected_corners.size(), corner);
      end
      case (r.prim_mode)
         MODE_TRIANGLES:              modulus = 3;
         MODE_STRIP, MODE_QUAD_STRIP: modulus = 2;
         default:                     modulus = 4;
      endcase
      asm_phase   = 2'((pos + 1) % modulus);
      asm_seen    = (seen < 3) ? 2'(seen + 1) : 2'd3;
      asm_hist[2] = h1;
      asm_hist[1] = h0;
      asm_hist[0] = cur;
   endtask

   // request driver
   always @(posedge clock) begin : drive_requests
      logic    next_valid;
      req_type next_data;
      logic    took;
      took       = req_valid && !req_stall;
      next_valid = req_valid;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (took) begin
            void'(pending_requests.pop_front());
            next_valid = 1'b0;
            sent++;
            if (sent == DRAIN_AT)
               drain_wait = 1'b1;
         end else if (drain_wait && expected_corners.size() == 0 && !rsp_valid) begin
            drain_wait = 1'b0;
         end
         if (!next_valid && !drain_wait) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               if (pending_requests.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
                  gap_left = $urandom_range(0, 2);
               end else begin
                  next_valid = 1'b1;
                  next_data  = pending_requests[0];
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // prediction, corner checking and receiver stalls
   always @(posedge clock) begin : watch_corners
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            if (req_valid && !req_stall) begin
               assemble_corners(req_data);
               requests_taken++;
            end
            if (rsp_valid && !rsp_stall) begin
               if (expected_corners.size() == 0) begin
                  $error("unexpected corner: ref %h slot %h last %b",
                         rsp_data.corner_ref, rsp_data.corner_transform,
                         rsp_data.last_of_run);
                  errors++;
               end else begin
                  want = expected_corners.pop_front();
                  corners_checked++;
                  if (rsp_data.corner_ref !== want.corner_ref) begin
                     $error("corner_ref: expected %h, got %h",
                            want.corner_ref, rsp_data.corner_ref);
                     errors++;
                  end
                  if (rsp_data.corner_transform !== want.corner_transform) begin
                     $error("corner_transform: expected %h, got %h",
                            want.corner_transform, rsp_data.corner_transform);
                     errors++;
                  end
                  if (rsp_data.last_of_run !== want.last_of_run) begin
                     $error("last_of_run: expected %b, got %b",
                            want.last_of_run, rsp_data.last_of_run);
                     errors++;
                  end
               end
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else if (pending_requests.size() >= CALM_TAIL
                         && $urandom_range(0, 4) == 0) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : run
      logic [MODE_W-1:0] mode;
      int                len;

      // vertices before any shape start count as a new shape
      push_vertex(16'h0000, 1'b0, MODE_TRIANGLES, 1'b1, 8'h00);
      push_vertex(16'hFFFF, 1'b0, MODE_TRIANGLES, 1'b1, 8'hFF);
      push_vertex(16'h8001, 1'b0, MODE_TRIANGLES, 1'b1, 8'h01);
      push_shape(MODE_STRIP, 1'b1, 8'hAA, 4);
      push_shape(MODE_FAN, 1'b1, 8'h55, 3);
      push_shape(MODE_QUADS, 1'b1, 8'hFF, 4);
      push_shape(MODE_QUAD_STRIP, 1'b1, 8'h00, 4);
      push_shape(MODE_STRIP, 1'b0, 8'h7F, 3);
      // unknown modes, then a switch to polygon mid-shape
      push_vertex(16'hFFFF, 1'b1, MODE_NONE_A, 1'b1, 8'h80);
      push_vertex(16'h0001, 1'b0, MODE_NONE_B, 1'b1, 8'h80);
      push_vertex(16'hFFFE, 1'b0, MODE_POLYGON, 1'b1, 8'hFE);

      while (pending_requests.size() < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: push_vertex(REF_W'($urandom), 1'($urandom), MODE_W'($urandom),
                           1'($urandom), SLOT_W'($urandom));
            1: begin
               len = $urandom_range(2, 7);
               push_vertex(REF_W'($urandom), 1'b1, MODE_W'($urandom), 1'b1, SLOT_W'($urandom));
               for (int i = 1; i < len; i++)
                  push_vertex(REF_W'($urandom), 1'b0, MODE_W'($urandom_range(0, 5)),
                              $urandom_range(0, 5) != 0, SLOT_W'($urandom));
            end
            default: begin
               mode = MODE_W'($urandom_range(0, 6));
               if (mode == MODE_NONE_A && $urandom_range(0, 1) == 1)
                  mode = MODE_NONE_B;
               push_shape(mode, $urandom_range(0, 7) != 0, SLOT_W'($urandom),
                          $urandom_range(1, 9));
            end
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_corners.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d vertex requests across all primitive modes, unfilled and unknown",
               requests_taken);
      $display("shapes and mid-shape changes; %0d triangle corners checked.",
               corners_checked);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
